// ===== src/hia_pkg.sv =====
// shared types, widths and codes for the handle index allocator
package hia_pkg;

    localparam int POOL_CAPACITY = 1024;
    localparam int STACK_AW      = $clog2(POOL_CAPACITY);

    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int MAXD_W      = 11;
    localparam int ADDR_W      = 48;
    localparam int STRIDE_W    = 13;
    localparam int PROD_W      = IDX_W + STRIDE_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 48;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 72;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DESC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 2'd2;

    localparam logic [MAXD_W-1:0]   RST_MAX_DESC = 11'd1024;
    localparam logic [ADDR_W-1:0]   RST_BASE     = 48'd0;
    localparam logic [STRIDE_W-1:0] RST_STRIDE   = 13'd32;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_NO_LIVE   = 2'd2
    } status_t;

    typedef struct packed {
        logic start;
        logic load_idx;
        logic mult;
        logic sum;
    } cmd_t;

endpackage

// ===== src/handle_index_allocator.sv =====
// handle index allocator top level
// A request is accepted only while no other request is being worked on. The
// counters update and the free-stack read starts at the accepting edge; the
// read, mult and sum states then take the fresh or popped index (the latter
// from the registered stack memory), form index times stride and add the
// 48-bit base, the last of them writing the output register, so a new
// request is accepted only after the previous one has written its result.
// The output register lets the next request be accepted while a result
// waits; that request stalls at its base add until the register has room.
// Requests are allocate (tuser low) or free (tuser high). Allocation hands out
// fresh indices in order up to the configured maximum, then pops the most
// recently freed index; an empty pool gives status exhausted and no change,
// and a free with no live slots gives status no-live and no change. Free
// indices are not checked. The free stack memory is not cleared after reset.
module handle_index_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [hia_pkg::IN_TDATA_W-1:0]      s_tdata,  // free_index, zero pad
    input  logic                                s_tuser,  // mode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // slot_index, slot_address, status, live_count, zero pad
    output logic [hia_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [hia_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hia_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import hia_pkg::*;

    cmd_t cmd;

    hia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    hia_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .req_mode       (s_tuser),
        .req_free_index (s_tdata[IDX_W-1:0]),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result         (m_tdata)
    );

endmodule

// ===== src/hia_ram.sv =====
// generic single write, single read ram with registered read data
module hia_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/hia_ctrl.sv =====
// request sequencer for the handle index allocator
module hia_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output hia_pkg::cmd_t cmd
);
    import hia_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_MULT = 4'b0100,
        ST_SUM  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_full_reg;
    logic   out_full_next;
    logic   out_room;
    logic   load_out;

    // output register free now or emptied at this edge
    assign out_room = !out_full_reg || m_tready;
    assign load_out = (state_reg == ST_SUM) && out_room;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_MULT;
            ST_MULT: state_next = ST_SUM;
            ST_SUM:
            begin
                if (out_room)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_full_next = out_full_reg;
        if (load_out)
        begin
            out_full_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    assign s_tready     = (state_reg == ST_IDLE);
    assign m_tvalid     = out_full_reg;
    assign cmd.start    = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.load_idx = (state_reg == ST_READ);
    assign cmd.mult     = (state_reg == ST_MULT);
    assign cmd.sum      = load_out;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped before it was taken");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in progress");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.load_idx, cmd.mult, cmd.sum}))
        else $error("more than one datapath command active");

endmodule

// ===== src/hia_dp.sv =====
// counters, free stack, address arithmetic and result register
module hia_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hia_pkg::cmd_t                    cmd,
    input  logic                             req_mode,
    input  logic [hia_pkg::IDX_W-1:0]        req_free_index,
    input  logic                             cfg_we,
    input  logic [hia_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hia_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [hia_pkg::OUT_TDATA_W-1:0]  result
);
    import hia_pkg::*;

    logic [MAXD_W-1:0]   max_desc_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [STRIDE_W-1:0] stride_reg;

    logic [CNT_W-1:0] next_fresh_reg;
    logic [CNT_W-1:0] next_fresh_next;
    logic [CNT_W-1:0] depth_reg;
    logic [CNT_W-1:0] depth_next;
    logic [CNT_W-1:0] live_reg;
    logic [CNT_W-1:0] live_next;

    logic [IDX_W-1:0]       fresh_idx_reg;
    logic                   ok_reg;
    logic                   from_ram_reg;
    status_t                status_reg;
    logic [CNT_W-1:0]       res_live_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [OUT_TDATA_W-1:0] out_reg;

    logic              fresh_ok;
    logic              stack_some;
    logic              stack_room;
    logic              push;
    logic              pop;
    logic [CNT_W-1:0]  depth_dec;
    logic [IDX_W-1:0]  ram_rdata;
    logic [ADDR_W-1:0] slot_addr;

    assign fresh_ok   = (next_fresh_reg < CNT_W'(POOL_CAPACITY))
                        && (next_fresh_reg < max_desc_reg);
    assign stack_some = (depth_reg != '0);
    assign stack_room = (depth_reg < CNT_W'(POOL_CAPACITY));
    assign depth_dec  = depth_reg - CNT_W'(1);
    assign pop        = cmd.start && (req_mode == MODE_ALLOC) && !fresh_ok && stack_some;
    assign push       = cmd.start && (req_mode == MODE_FREE) && (live_reg != '0)
                        && stack_room;
    assign slot_addr  = ok_reg ? (base_reg + ADDR_W'(prod_reg)) : '0;

    hia_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_CAPACITY)
    ) u_stack (
        .clk   (clk),
        .we    (push),
        .waddr (depth_reg[STACK_AW-1:0]),
        .wdata (req_free_index),
        .re    (pop),
        .raddr (depth_dec[STACK_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        next_fresh_next = next_fresh_reg;
        depth_next      = depth_reg;
        live_next       = live_reg;
        if (cmd.start)
        begin
            if (req_mode == MODE_ALLOC)
            begin
                if (fresh_ok)
                begin
                    next_fresh_next = next_fresh_reg + CNT_W'(1);
                    live_next       = live_reg + CNT_W'(1);
                end
                else if (stack_some)
                begin
                    depth_next = depth_dec;
                    live_next  = live_reg + CNT_W'(1);
                end
            end
            else if (live_reg != '0)
            begin
                if (stack_room)
                begin
                    depth_next = depth_reg + CNT_W'(1);
                end
                live_next = live_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_desc_reg   <= RST_MAX_DESC;
            base_reg       <= RST_BASE;
            stride_reg     <= RST_STRIDE;
            next_fresh_reg <= '0;
            depth_reg      <= '0;
            live_reg       <= '0;
        end
        else
        begin
            next_fresh_reg <= next_fresh_next;
            depth_reg      <= depth_next;
            live_reg       <= live_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_DESC: max_desc_reg <= cfg_data[MAXD_W-1:0];
                    CFG_BASE:     base_reg     <= cfg_data[ADDR_W-1:0];
                    CFG_STRIDE:   stride_reg   <= cfg_data[STRIDE_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            fresh_idx_reg <= next_fresh_reg[IDX_W-1:0];
            from_ram_reg  <= !fresh_ok;
            res_live_reg  <= live_next;
            if (req_mode == MODE_ALLOC)
            begin
                ok_reg     <= fresh_ok || stack_some;
                status_reg <= (fresh_ok || stack_some) ? STAT_OK : STAT_EXHAUSTED;
            end
            else
            begin
                ok_reg     <= 1'b0;
                status_reg <= (live_reg != '0) ? STAT_OK : STAT_NO_LIVE;
            end
        end
        if (cmd.load_idx)
        begin
            if (!ok_reg)
            begin
                idx_reg <= '0;
            end
            else if (from_ram_reg)
            begin
                idx_reg <= ram_rdata;
            end
            else
            begin
                idx_reg <= fresh_idx_reg;
            end
        end
        if (cmd.mult)
        begin
            prod_reg <= PROD_W'(idx_reg) * PROD_W'(stride_reg);
        end
        if (cmd.sum)
        begin
            out_reg <= {1'b0, res_live_reg, status_reg, slot_addr, idx_reg};
        end
    end

    assign result = out_reg;

endmodule
